/* rtl/core/plc_pkg.sv */
// Shared types and constants for the line-follow PID controller.
// Holds the configuration record, register indexes and fixed datapath widths.
// No dependencies.
`default_nettype none

package plc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int SAMPLE_W   = 8;
	localparam int GAIN_W     = 24;
	localparam int LIMIT_W    = 7;
	localparam int DRIVE_W    = 8;
	localparam int ERR_W      = 9;
	localparam int DIFF_W     = 10;

	localparam int P_W        = GAIN_W + ERR_W + 1;
	localparam int D_W        = GAIN_W + DIFF_W + 1;
	localparam int PD_W       = D_W + 1;

	// Integral magnitude is capped well above anything the other terms can reach.
	localparam int IMAG_W     = 34;
	localparam int IMAG_LO_W  = 17;
	localparam int IMAG_HI_W  = IMAG_W - IMAG_LO_W;
	localparam int IPROD_W    = GAIN_W + IMAG_LO_W;
	localparam int IFULL_W    = IPROD_W + IMAG_LO_W;
	localparam int ISAT_W     = 36;
	localparam int TOT_W      = 37;

	localparam logic [IMAG_W-1:0] IMAG_MAX = {IMAG_W{1'b1}};
	localparam logic [ISAT_W-1:0] ISAT_VAL = {1'b1, {(ISAT_W-1){1'b0}}};

	localparam logic [SAMPLE_W-1:0] TARGET_RST = 8'd20;
	localparam logic [GAIN_W-1:0]   GAIN_P_RST = 24'd24904;
	localparam logic [GAIN_W-1:0]   GAIN_I_RST = 24'd8;
	localparam logic [GAIN_W-1:0]   GAIN_D_RST = 24'd442368;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_GAIN_P = 3'd1,
		REG_GAIN_I = 3'd2,
		REG_GAIN_D = 3'd3,
		REG_LIMIT  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] target_level;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i_dt;
		logic [GAIN_W-1:0]   gain_d_dt;
		logic [LIMIT_W-1:0]  output_limit;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/pid_line_follow_controller.sv */
// Line-follow PID controller: one sensor sample in, one clamped drive value out.
// Each sample travels from the input transfer to out_valid through a six-register pipeline.
// Throughput is one sample per cycle; the whole pipeline holds while a result waits.
// Reset clears the error history and accumulator, empties the pipeline, and
// loads the default target, gains and limit. Depends on plc_pkg and the plc_* modules.
`default_nettype none

module pid_line_follow_controller #(
	parameter int ACC_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [plc_pkg::SAMPLE_W-1:0]        sensor_sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [plc_pkg::DRIVE_W-1:0]       drive_value,
	output logic                                     clamped,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [plc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [plc_pkg::GAIN_W-1:0]          cfg_data
);

	plc_pkg::cfg_t                       cfg;
	logic                                adv;
	logic                                valid_s1;
	logic signed [plc_pkg::ERR_W-1:0]    err_s1;
	logic signed [plc_pkg::DIFF_W-1:0]   diff_s1;
	logic signed [ACC_WIDTH-1:0]         acc_s1;
	logic                                valid_s5;
	logic signed [plc_pkg::TOT_W-1:0]    total_s5;
	logic signed [plc_pkg::DRIVE_W-1:0]  lim_s;

	assign adv      = !(out_valid && !out_ready);
	assign in_ready = adv;
	assign lim_s    = $signed({1'b0, cfg.output_limit});

	plc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plc_err_acc #(.ACC_WIDTH(ACC_WIDTH)) u_err (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.sensor_sample (sensor_sample),
		.target_level  (cfg.target_level),
		.valid_s1      (valid_s1),
		.err_s1        (err_s1),
		.diff_s1       (diff_s1),
		.acc_s1        (acc_s1)
	);

	plc_terms #(.ACC_WIDTH(ACC_WIDTH)) u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.err_s1   (err_s1),
		.diff_s1  (diff_s1),
		.acc_s1   (acc_s1),
		.cfg      (cfg),
		.valid_s5 (valid_s5),
		.total_s5 (total_s5)
	);

	plc_clamp_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_s5     (valid_s5),
		.total_s5     (total_s5),
		.output_limit (cfg.output_limit),
		.out_valid    (out_valid),
		.drive_value  (drive_value),
		.clamped      (clamped)
	);

	// The pipeline only holds back input while a finished result is waiting.
	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input held back with no result waiting");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clamped) |-> (drive_value == lim_s || drive_value == -lim_s))
		else $error("clamped result is not at the limit");

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !clamped) |-> (drive_value <= lim_s && drive_value >= -lim_s))
		else $error("unclamped result exceeds the limit");

	a_no_full_negative: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_value != {1'b1, {(plc_pkg::DRIVE_W-1){1'b0}}}))
		else $error("drive value out of symmetric range");

endmodule

`default_nettype wire

/* rtl/core/plc_cfg_regs.sv */
// Configuration register file for the line-follow PID controller.
// Depends on plc_pkg for the register record and indexes.
`default_nettype none

module plc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [plc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plc_pkg::GAIN_W-1:0]     cfg_data,
	output plc_pkg::cfg_t                       cfg
);

	plc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level <= plc_pkg::TARGET_RST;
			cfg_q.gain_p       <= plc_pkg::GAIN_P_RST;
			cfg_q.gain_i_dt    <= plc_pkg::GAIN_I_RST;
			cfg_q.gain_d_dt    <= plc_pkg::GAIN_D_RST;
			cfg_q.output_limit <= plc_pkg::LIMIT_RST;
		end else if (cfg_valid) begin
			case (plc_pkg::reg_index_t'(cfg_index))
				plc_pkg::REG_TARGET: begin
					cfg_q.target_level <= cfg_data[plc_pkg::SAMPLE_W-1:0];
				end
				plc_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data;
				end
				plc_pkg::REG_GAIN_I: begin
					cfg_q.gain_i_dt <= cfg_data;
				end
				plc_pkg::REG_GAIN_D: begin
					cfg_q.gain_d_dt <= cfg_data;
				end
				plc_pkg::REG_LIMIT: begin
					cfg_q.output_limit <= cfg_data[plc_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/plc_err_acc.sv */
// Input stage: error, error difference and the saturating trapezoidal accumulator.
// Depends on plc_pkg for widths; holds the previous error and accumulator state.
`default_nettype none

module plc_err_acc #(
	parameter int ACC_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                in_valid,
	input  wire logic [plc_pkg::SAMPLE_W-1:0]        sensor_sample,
	input  wire logic [plc_pkg::SAMPLE_W-1:0]        target_level,
	output logic                                     valid_s1,
	output logic signed [plc_pkg::ERR_W-1:0]         err_s1,
	output logic signed [plc_pkg::DIFF_W-1:0]        diff_s1,
	output logic signed [ACC_WIDTH-1:0]              acc_s1
);

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic signed [plc_pkg::ERR_W-1:0]  prev_q;
	logic signed [ACC_WIDTH-1:0]       acc_q;
	logic signed [plc_pkg::ERR_W-1:0]  err_c;
	logic signed [plc_pkg::DIFF_W-1:0] pair_c;
	logic signed [plc_pkg::DIFF_W-1:0] diff_c;
	logic signed [ACC_WIDTH:0]         sum_c;
	logic signed [ACC_WIDTH-1:0]       acc_c;
	logic                              accept;

	assign accept = in_valid && adv;

	always_comb begin
		err_c  = $signed({1'b0, sensor_sample}) - $signed({1'b0, target_level});
		pair_c = plc_pkg::DIFF_W'(err_c) + plc_pkg::DIFF_W'(prev_q);
		diff_c = plc_pkg::DIFF_W'(err_c) - plc_pkg::DIFF_W'(prev_q);
		sum_c  = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(pair_c);
		if (sum_c[ACC_WIDTH] != sum_c[ACC_WIDTH-1]) begin
			acc_c = sum_c[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_c = sum_c[ACC_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			acc_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				prev_q <= err_c;
				acc_q  <= acc_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1  <= err_c;
			diff_s1 <= diff_c;
			acc_s1  <= acc_c;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/plc_terms.sv */
// Product stages: proportional, derivative and split integral products, then the total.
// Depends on plc_pkg for widths and the integral saturation constants.
`default_nettype none

module plc_terms #(
	parameter int ACC_WIDTH = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                valid_s1,
	input  wire logic signed [plc_pkg::ERR_W-1:0]    err_s1,
	input  wire logic signed [plc_pkg::DIFF_W-1:0]   diff_s1,
	input  wire logic signed [ACC_WIDTH-1:0]         acc_s1,
	input  wire plc_pkg::cfg_t                       cfg,
	output logic                                     valid_s5,
	output logic signed [plc_pkg::TOT_W-1:0]         total_s5
);

	localparam int EXT_W = (ACC_WIDTH > plc_pkg::IMAG_W) ? ACC_WIDTH : plc_pkg::IMAG_W;

	logic [ACC_WIDTH-1:0]                amag_c;
	logic [EXT_W-1:0]                    aext_c;
	logic [plc_pkg::IMAG_W-1:0]          imag_c;
	logic [plc_pkg::IFULL_W-1:0]         ifull_c;
	logic signed [plc_pkg::TOT_W-1:0]    iterm_c;

	logic                                valid_s2;
	logic                                valid_s3;
	logic                                valid_s4;
	logic signed [plc_pkg::P_W-1:0]      p_s2;
	logic signed [plc_pkg::D_W-1:0]      d_s2;
	logic [plc_pkg::IMAG_W-1:0]          imag_s2;
	logic                                ineg_s2;
	logic signed [plc_pkg::PD_W-1:0]     pd_s3;
	logic [plc_pkg::IPROD_W-1:0]         ilo_s3;
	logic [plc_pkg::IPROD_W-1:0]         ihi_s3;
	logic                                ineg_s3;
	logic signed [plc_pkg::PD_W-1:0]     pd_s4;
	logic [plc_pkg::ISAT_W-1:0]          isat_s4;
	logic                                ineg_s4;

	always_comb begin
		amag_c = acc_s1[ACC_WIDTH-1] ? (~acc_s1 + 1'b1) : acc_s1;
		aext_c = EXT_W'(amag_c);
		if (aext_c > EXT_W'(plc_pkg::IMAG_MAX)) begin
			imag_c = plc_pkg::IMAG_MAX;
		end else begin
			imag_c = aext_c[plc_pkg::IMAG_W-1:0];
		end
		ifull_c = {ihi_s3, {plc_pkg::IMAG_LO_W{1'b0}}} + plc_pkg::IFULL_W'(ilo_s3);
		iterm_c = $signed(plc_pkg::TOT_W'(isat_s4));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2    <= $signed({1'b0, cfg.gain_p}) * err_s1;
			d_s2    <= $signed({1'b0, cfg.gain_d_dt}) * diff_s1;
			imag_s2 <= imag_c;
			ineg_s2 <= acc_s1[ACC_WIDTH-1];

			pd_s3   <= plc_pkg::PD_W'(p_s2) + plc_pkg::PD_W'(d_s2);
			ilo_s3  <= cfg.gain_i_dt * imag_s2[plc_pkg::IMAG_LO_W-1:0];
			ihi_s3  <= cfg.gain_i_dt * imag_s2[plc_pkg::IMAG_W-1:plc_pkg::IMAG_LO_W];
			ineg_s3 <= ineg_s2;

			pd_s4   <= pd_s3;
			isat_s4 <= (ifull_c > plc_pkg::IFULL_W'(plc_pkg::ISAT_VAL)) ?
				plc_pkg::ISAT_VAL : ifull_c[plc_pkg::ISAT_W-1:0];
			ineg_s4 <= ineg_s3;

			total_s5 <= ineg_s4 ? (plc_pkg::TOT_W'(pd_s4) - iterm_c) :
				(plc_pkg::TOT_W'(pd_s4) + iterm_c);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/plc_clamp_out.sv */
// Output stage: symmetric clamp, truncation toward zero and the result register.
// Depends on plc_pkg for widths.
`default_nettype none

module plc_clamp_out #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                valid_s5,
	input  wire logic signed [plc_pkg::TOT_W-1:0]    total_s5,
	input  wire logic [plc_pkg::LIMIT_W-1:0]         output_limit,
	output logic                                     out_valid,
	output logic signed [plc_pkg::DRIVE_W-1:0]       drive_value,
	output logic                                     clamped
);

	logic [plc_pkg::TOT_W-1:0]         tmag_c;
	logic [plc_pkg::TOT_W-1:0]         lim_c;
	logic [plc_pkg::TOT_W-1:0]         shifted_c;
	logic                              over_c;
	logic [plc_pkg::LIMIT_W-1:0]       val_c;
	logic signed [plc_pkg::DRIVE_W-1:0] drive_c;

	always_comb begin
		tmag_c    = total_s5[plc_pkg::TOT_W-1] ? (~total_s5 + 1'b1) : total_s5;
		lim_c     = plc_pkg::TOT_W'({output_limit, {FRAC_BITS{1'b0}}});
		shifted_c = tmag_c >> FRAC_BITS;
		over_c    = tmag_c > lim_c;
		val_c     = over_c ? output_limit : shifted_c[plc_pkg::LIMIT_W-1:0];
		drive_c   = total_s5[plc_pkg::TOT_W-1] ? -$signed({1'b0, val_c}) :
			$signed({1'b0, val_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s5) begin
			drive_value <= drive_c;
			clamped     <= over_c;
		end
	end

endmodule

`default_nettype wire

/* verif/pid_line_follow_controller_tb.sv */
// Self-checking testbench for the line-follow PID controller.
// Drives sensor samples and register writes, predicts every drive value and clamp flag,
// and compares them in order. Depends on plc_pkg and pid_line_follow_controller.
`timescale 1ns / 100ps

module pid_line_follow_controller_tb;

	localparam int     FRAC          = 16;
	localparam longint PAIR_SUM_MAX  = 64'sd2147483647;
	localparam longint PAIR_SUM_MIN  = -64'sd2147483648;
	localparam longint TERM_CAP      = 64'sd1099511627776;
	localparam int     STALL_LIMIT   = 5000;
	localparam int     HOLD_CYCLES   = 100;
	localparam int     RANDOM_ITEMS  = 1300;
	localparam int     SETTLE_CYCLES = 20;

	localparam logic [plc_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
	localparam logic [plc_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [plc_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [plc_pkg::GAIN_W-1:0] GAIN_ONE  = 24'h010000;
	localparam logic [plc_pkg::GAIN_W-1:0] GAIN_HALF = 24'h008000;
	localparam logic [plc_pkg::GAIN_W-1:0] GAIN_MAX  = 24'hFFFFFF;

	typedef struct packed {
		logic signed [plc_pkg::DRIVE_W-1:0] drive;
		logic                               clamp;
	} drive_t;

	typedef struct packed {
		logic   fixed;
		drive_t result;
	} preset_t;

	typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [plc_pkg::CFG_IDX_W-1:0]   idx;
		logic [plc_pkg::GAIN_W-1:0]      data;
		logic [plc_pkg::SAMPLE_W-1:0]    sample;
		logic                            fixed;
		drive_t                          result;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [plc_pkg::SAMPLE_W-1:0]        sensor_sample;
	logic                                out_valid;
	logic                                out_ready;
	logic signed [plc_pkg::DRIVE_W-1:0]  drive_value;
	logic                                clamped;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [plc_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [plc_pkg::GAIN_W-1:0]          cfg_data;

	logic [plc_pkg::SAMPLE_W-1:0] m_target;
	logic [plc_pkg::GAIN_W-1:0]   m_kp;
	logic [plc_pkg::GAIN_W-1:0]   m_ki;
	logic [plc_pkg::GAIN_W-1:0]   m_kd;
	logic [plc_pkg::LIMIT_W-1:0]  m_limit;
	int                           m_prev_err;
	longint                       m_pair_sum;

	drive_t    drive_q[$];
	preset_t   preset_q[$];
	stim_row_t steer_rows[$];

	int mismatch_cnt;
	int random_sent;
	bit idle_on;
	bit hold_out_req;
	bit windup;

	pid_line_follow_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sensor_sample (sensor_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_value   (drive_value),
		.clamped       (clamped),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint gain_term(input logic [plc_pkg::GAIN_W-1:0] g,
		input longint v);
		longint mag;
		longint prod;
		mag = (v < 0) ? -v : v;
		prod = mag * longint'({40'd0, g});
		if (prod > TERM_CAP)
			prod = TERM_CAP;
		return (v < 0) ? -prod : prod;
	endfunction

	function automatic drive_t control_step(input logic [plc_pkg::SAMPLE_W-1:0] s);
		int     err;
		longint total;
		longint bound;
		longint out_v;
		drive_t r;
		err = int'(s) - int'(m_target);
		m_pair_sum = m_pair_sum + err + m_prev_err;
		if (m_pair_sum > PAIR_SUM_MAX)
			m_pair_sum = PAIR_SUM_MAX;
		else if (m_pair_sum < PAIR_SUM_MIN)
			m_pair_sum = PAIR_SUM_MIN;
		total = gain_term(m_kp, err) + gain_term(m_ki, m_pair_sum)
			+ gain_term(m_kd, err - m_prev_err);
		m_prev_err = err;
		bound = longint'({57'd0, m_limit}) <<< FRAC;
		r.clamp = 1'b1;
		if (total > bound) begin
			out_v = longint'({57'd0, m_limit});
		end else if (total < -bound) begin
			out_v = -longint'({57'd0, m_limit});
		end else begin
			r.clamp = 1'b0;
			out_v = (total < 0) ? -((-total) >>> FRAC) : (total >>> FRAC);
		end
		r.drive = out_v[plc_pkg::DRIVE_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		drive_t  want;
		preset_t p;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					plc_pkg::REG_TARGET: m_target = cfg_data[plc_pkg::SAMPLE_W-1:0];
					plc_pkg::REG_GAIN_P: m_kp = cfg_data;
					plc_pkg::REG_GAIN_I: m_ki = cfg_data;
					plc_pkg::REG_GAIN_D: m_kd = cfg_data;
					plc_pkg::REG_LIMIT:  m_limit = cfg_data[plc_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = control_step(sensor_sample);
				if (preset_q.size() != 0) begin
					p = preset_q.pop_front();
					if (p.fixed)
						want = p.result;
				end
				drive_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					$error("unexpected result: drive_value %0d, clamped %0d", drive_value, clamped);
					mismatch_cnt++;
				end else begin
					want = drive_q.pop_front();
					if (drive_value !== want.drive) begin
						$error("drive_value mismatch: expected %0d, actual %0d",
							want.drive, drive_value);
						mismatch_cnt++;
					end
					if (clamped !== want.clamp) begin
						$error("clamped mismatch: expected %0d, actual %0d", want.clamp, clamped);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin : result_sink
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out_req) begin
				hold_left = HOLD_CYCLES;
				hold_out_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = idle_gap();
				if (stall_left > 0) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("pid_line_follow_controller_tb failed");
		$finish;
	end

	task automatic send_sample(input logic [plc_pkg::SAMPLE_W-1:0] s, input preset_t p);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		preset_q.push_back(p);
		in_valid <= 1'b1;
		sensor_sample <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_q.size() != 0 || preset_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [plc_pkg::CFG_IDX_W-1:0] idx,
		input logic [plc_pkg::GAIN_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [plc_pkg::GAIN_W-1:0] pick_gain(input int moderate);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return plc_pkg::GAIN_W'($urandom_range(0, moderate));
			default: return plc_pkg::GAIN_W'($urandom);
		endcase
	endfunction

	task automatic retune();
		logic [plc_pkg::SAMPLE_W-1:0] tgt;
		logic [plc_pkg::LIMIT_W-1:0]  lim;
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 3))
				0: tgt = '0;
				1: tgt = '1;
				default: tgt = plc_pkg::SAMPLE_W'($urandom);
			endcase
			write_reg(plc_pkg::REG_TARGET, {16'($urandom), tgt});
		end
		if ($urandom_range(0, 2) != 0)
			write_reg(plc_pkg::REG_GAIN_P, pick_gain(24'h030000));
		if ($urandom_range(0, 2) != 0)
			write_reg(plc_pkg::REG_GAIN_I, pick_gain(24'h000200));
		if ($urandom_range(0, 2) != 0)
			write_reg(plc_pkg::REG_GAIN_D, pick_gain(24'h0C0000));
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 3))
				0: lim = '0;
				1: lim = '1;
				default: lim = plc_pkg::LIMIT_W'($urandom);
			endcase
			write_reg(plc_pkg::REG_LIMIT, {17'($urandom), lim});
		end
		if ($urandom_range(0, 5) == 0)
			write_reg(REG_SPARE_5 + plc_pkg::CFG_IDX_W'($urandom_range(0, 2)),
				plc_pkg::GAIN_W'($urandom));
	endtask

	function automatic logic [plc_pkg::SAMPLE_W-1:0] draw_sample();
		if (windup)
			return ($urandom_range(0, 3) == 0) ?
				plc_pkg::SAMPLE_W'($urandom_range(240, 255)) : '1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return m_target + plc_pkg::SAMPLE_W'($urandom_range(0, 10))
				- plc_pkg::SAMPLE_W'(5);
			default: return plc_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input logic [plc_pkg::CFG_IDX_W-1:0] idx,
		input logic [plc_pkg::GAIN_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.sample = '0;
		r.fixed = 1'b0;
		r.result = '0;
		return r;
	endfunction

	function automatic stim_row_t sample_row(input logic [plc_pkg::SAMPLE_W-1:0] s,
		input logic fixed, input logic signed [plc_pkg::DRIVE_W-1:0] d, input logic c);
		stim_row_t r;
		r.kind = ROW_SAMPLE;
		r.idx = '0;
		r.data = '0;
		r.sample = s;
		r.fixed = fixed;
		r.result.drive = d;
		r.result.clamp = c;
		return r;
	endfunction

	initial begin : stimulus
		preset_t p;
		int      n;
		int      phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sensor_sample = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_target = plc_pkg::TARGET_RST;
		m_kp = plc_pkg::GAIN_P_RST;
		m_ki = plc_pkg::GAIN_I_RST;
		m_kd = plc_pkg::GAIN_D_RST;
		m_limit = plc_pkg::LIMIT_RST;
		m_prev_err = 0;
		m_pair_sum = 0;
		mismatch_cnt = 0;
		random_sent = 0;
		idle_on = 1'b1;
		hold_out_req = 1'b0;
		windup = 1'b0;

		// Defaults after reset; the first step sees a zero previous error.
		steer_rows.push_back(sample_row(8'd20, 1'b1, 8'sd0, 1'b0));
		steer_rows.push_back(sample_row(8'd255, 1'b1, 8'sd100, 1'b1));
		steer_rows.push_back(sample_row(8'd0, 1'b1, -8'sd100, 1'b1));
		steer_rows.push_back(sample_row(8'd20, 1'b1, 8'sd100, 1'b1));
		// Pure proportional path with unity gain: a sum exactly at the limit is not a clamp.
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'd0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_P, GAIN_ONE));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_I, 24'd0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_D, 24'd0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_LIMIT, 24'd100));
		steer_rows.push_back(sample_row(8'd100, 1'b1, 8'sd100, 1'b0));
		steer_rows.push_back(sample_row(8'd101, 1'b1, 8'sd100, 1'b1));
		steer_rows.push_back(sample_row(8'd0, 1'b1, 8'sd0, 1'b0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_LIMIT, 24'd127));
		steer_rows.push_back(sample_row(8'd127, 1'b1, 8'sd127, 1'b0));
		steer_rows.push_back(sample_row(8'd255, 1'b1, 8'sd127, 1'b1));
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'd255));
		steer_rows.push_back(sample_row(8'd128, 1'b1, -8'sd127, 1'b0));
		steer_rows.push_back(sample_row(8'd0, 1'b1, -8'sd127, 1'b1));
		steer_rows.push_back(sample_row(8'd255, 1'b1, 8'sd0, 1'b0));
		// Half gain shows truncation toward zero on both signs.
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_P, GAIN_HALF));
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'd0));
		steer_rows.push_back(sample_row(8'd3, 1'b1, 8'sd1, 1'b0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'd255));
		steer_rows.push_back(sample_row(8'd252, 1'b1, -8'sd1, 1'b0));
		// A zero limit forces the output to zero and flags any nonzero sum.
		steer_rows.push_back(cfg_row(plc_pkg::REG_LIMIT, 24'd0));
		steer_rows.push_back(sample_row(8'd252, 1'b1, 8'sd0, 1'b1));
		steer_rows.push_back(sample_row(8'd255, 1'b1, 8'sd0, 1'b0));
		// Writes to unmapped indexes must leave every register alone.
		steer_rows.push_back(cfg_row(REG_SPARE_5, 24'hFFFFFF));
		steer_rows.push_back(cfg_row(REG_SPARE_6, 24'h0000FF));
		steer_rows.push_back(cfg_row(REG_SPARE_7, 24'h5A5A5A));
		steer_rows.push_back(sample_row(8'd250, 1'b1, 8'sd0, 1'b1));
		// Only the low bits of the target and limit writes are used.
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'hABCD00));
		steer_rows.push_back(cfg_row(plc_pkg::REG_LIMIT, 24'hFFFF85));
		steer_rows.push_back(sample_row(8'd200, 1'b1, 8'sd5, 1'b1));
		steer_rows.push_back(sample_row(8'd9, 1'b1, 8'sd4, 1'b0));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_P, GAIN_MAX));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_I, GAIN_MAX));
		steer_rows.push_back(cfg_row(plc_pkg::REG_GAIN_D, GAIN_MAX));
		steer_rows.push_back(cfg_row(plc_pkg::REG_LIMIT, 24'h00007F));
		steer_rows.push_back(cfg_row(plc_pkg::REG_TARGET, 24'd128));
		steer_rows.push_back(sample_row(8'd0, 1'b0, 8'sd0, 1'b0));
		steer_rows.push_back(sample_row(8'd255, 1'b0, 8'sd0, 1'b0));
		steer_rows.push_back(sample_row(8'd128, 1'b0, 8'sd0, 1'b0));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (steer_rows[i]) begin
			if (steer_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(steer_rows[i].idx, steer_rows[i].data);
			end else begin
				p.fixed = steer_rows[i].fixed;
				p.result = steer_rows[i].result;
				send_sample(steer_rows[i].sample, p);
			end
		end

		p = '0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_idle();
			windup = (phase == 1);
			if (windup) begin
				// Long run of large errors drives the integral term into saturation.
				write_reg(plc_pkg::REG_TARGET, 24'd0);
				write_reg(plc_pkg::REG_GAIN_I, GAIN_MAX);
				write_reg(plc_pkg::REG_LIMIT, {17'($urandom), plc_pkg::LIMIT_W'($urandom)});
				n = 200;
			end else begin
				retune();
				n = $urandom_range(20, 80);
			end
			idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 3) begin
				idle_on = 1'b0;
				hold_out_req = 1'b1;
			end
			repeat (n) begin
				send_sample(draw_sample(), p);
				random_sent++;
			end
			phase++;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("pid_line_follow_controller_tb passed");
		else
			$display("pid_line_follow_controller_tb failed");
		$finish;
	end

endmodule
